@@ rtl/nsr_pkg.sv @@
package nsr_pkg;

  // Default sizes of the radicand and of its fraction.
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed field widths of the result and of the configuration registers.
  localparam int ROOT_W     = 24;
  localparam int ITER_W     = 6;
  localparam int TOL_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GUESS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL      = 2'd2;

  // Register values after reset: guess 2.0, 25 steps, tolerance 7 LSB.
  localparam logic [ROOT_W-1:0] GUESS_RST    = 24'd131072;
  localparam logic [ITER_W-1:0] MAX_ITER_RST = 6'd25;
  localparam logic [TOL_W-1:0]  TOL_RST      = 16'd7;

  // Sequencer states.
  typedef enum logic [1:0] {
    NSR_IDLE,
    NSR_DIV,
    NSR_UPD
  } nsr_state_t;

endpackage

@@ rtl/nsr_div.sv @@
module nsr_div #(
  parameter int DATA_WIDTH = nsr_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = nsr_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [DATA_WIDTH-1:0]       dividend,
  input  logic [nsr_pkg::ROOT_W-1:0]  divisor,
  output logic                        done,
  output logic [nsr_pkg::ROOT_W-1:0]  quotient
);

  localparam int NUM_W = DATA_WIDTH + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int RW    = nsr_pkg::ROOT_W;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [RW-1:0]    rem_r;
  logic [RW-1:0]    rem_nxt;
  logic [RW-1:0]    div_r;
  logic [RW-1:0]    q_r;
  logic [RW-1:0]    q_nxt;
  logic             big_r;
  logic             big_nxt;
  logic [RW:0]      rem_sh;
  logic [RW-1:0]    rem_diff;
  logic             ge;

  // One restoring step: bring down the next numerator bit and try the subtract.
  // When the subtract succeeds the difference is below the divisor, so its low
  // bits are the whole new remainder.
  always_comb begin
    rem_sh   = {rem_r, num_r[NUM_W-1]};
    rem_diff = rem_sh[RW-1:0] - div_r;
    ge       = (rem_sh >= {1'b0, div_r});
    rem_nxt  = ge ? rem_diff : rem_sh[RW-1:0];
    // The quotient saturates once it would leave the root range and then holds.
    if (big_r || q_r[RW-1]) begin
      q_nxt   = '1;
      big_nxt = 1'b1;
    end else begin
      q_nxt   = {q_r[RW-2:0], ge};
      big_nxt = 1'b0;
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= NUM_W[CNT_W-1:0];
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (go) begin
      num_r <= {dividend, {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      q_r   <= '0;
      big_r <= 1'b0;
      div_r <= divisor;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      big_r <= big_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

@@ rtl/newton_square_root_unit.sv @@
// Fixed-point square root by Newton iteration x <- x + (n/x - x)/2.
// Input: raise start with in_radicand (signed, FRAC_BITS fraction bits); the
// item is taken at a clock edge where start is high and busy is low. busy stays
// high while the item iterates, and no new item is taken meanwhile.
// Output: out_valid is high for exactly one cycle with out_root, out_steps_taken
// and out_negative_error. The receiver cannot stall, so the result must be
// captured in that cycle.
// A negative or zero radicand, or an iteration limit of zero, gives its
// result in the cycle after the item is taken. Otherwise each Newton step
// runs the shared restoring divider, which produces one quotient bit per
// cycle, and then applies the step. The next item can be taken at the edge
// that ends the result cycle.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Index 0 is the starting guess, 1 the step limit, 2 the
// tolerance; other indexes are ignored. Write only while the unit is idle.
// Reset (rst_n low, synchronous) returns the unit to idle and loads the
// register defaults: guess 2.0, 25 steps, tolerance 7.
module newton_square_root_unit #(
  parameter int DATA_WIDTH = nsr_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = nsr_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [DATA_WIDTH-1:0]      in_radicand,
  output logic                              out_valid,
  output logic [nsr_pkg::ROOT_W-1:0]        out_root,
  output logic [nsr_pkg::ITER_W-1:0]        out_steps_taken,
  output logic                              out_negative_error,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nsr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int RW = nsr_pkg::ROOT_W;
  localparam int IW = nsr_pkg::ITER_W;

  nsr_pkg::nsr_state_t state_r, state_nxt;

  logic [RW-1:0]              guess_r;
  logic [IW-1:0]              max_iter_r;
  logic [nsr_pkg::TOL_W-1:0]  tol_r;

  logic [DATA_WIDTH-1:0] rad_r, rad_nxt;
  logic [RW-1:0]         x_r, x_nxt;
  logic [IW-1:0]         cnt_r, cnt_nxt;
  logic [RW-1:0]         mag_r, mag_nxt;
  logic                  up_r, up_nxt;

  logic          ov_r, ov_nxt;
  logic [RW-1:0] root_r, root_nxt;
  logic [IW-1:0] steps_r, steps_nxt;
  logic          nerr_r, nerr_nxt;

  logic                  div_go;
  logic [DATA_WIDTH-1:0] div_dividend;
  logic [RW-1:0]         div_divisor;
  logic                  div_done;
  logic [RW-1:0]         div_q;

  logic [RW-1:0] guess_eff;
  logic [RW-1:0] x_upd;
  logic [IW-1:0] cnt_inc;
  logic          accept;

  nsr_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign busy      = (state_r != nsr_pkg::NSR_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // A zero guess is taken as one LSB so that no step divides by zero.
  assign guess_eff = (guess_r == '0) ? RW'(1) : guess_r;
  assign x_upd     = up_r ? (x_r + mag_r) : (x_r - mag_r);
  assign cnt_inc   = cnt_r + IW'(1);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guess_r    <= nsr_pkg::GUESS_RST;
      max_iter_r <= nsr_pkg::MAX_ITER_RST;
      tol_r      <= nsr_pkg::TOL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nsr_pkg::CFG_GUESS:    guess_r    <= cfg_data[RW-1:0];
        nsr_pkg::CFG_MAX_ITER: max_iter_r <= cfg_data[IW-1:0];
        nsr_pkg::CFG_TOL:      tol_r      <= cfg_data[nsr_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: start a division, turn its quotient into a step, apply it.
  always_comb begin
    state_nxt    = state_r;
    rad_nxt      = rad_r;
    x_nxt        = x_r;
    cnt_nxt      = cnt_r;
    mag_nxt      = mag_r;
    up_nxt       = up_r;
    ov_nxt       = 1'b0;
    root_nxt     = root_r;
    steps_nxt    = steps_r;
    nerr_nxt     = nerr_r;
    div_go       = 1'b0;
    div_dividend = rad_r;
    div_divisor  = x_r;
    unique case (state_r)
      nsr_pkg::NSR_IDLE: begin
        if (accept) begin
          priority if (in_radicand[DATA_WIDTH-1]) begin
            ov_nxt    = 1'b1;
            root_nxt  = '0;
            steps_nxt = '0;
            nerr_nxt  = 1'b1;
          end else if (in_radicand == '0) begin
            ov_nxt    = 1'b1;
            root_nxt  = '0;
            steps_nxt = '0;
            nerr_nxt  = 1'b0;
          end else if (max_iter_r == '0) begin
            ov_nxt    = 1'b1;
            root_nxt  = guess_eff;
            steps_nxt = '0;
            nerr_nxt  = 1'b0;
          end else begin
            rad_nxt      = in_radicand;
            x_nxt        = guess_eff;
            cnt_nxt      = '0;
            div_go       = 1'b1;
            div_dividend = in_radicand;
            div_divisor  = guess_eff;
            state_nxt    = nsr_pkg::NSR_DIV;
          end
        end
      end
      nsr_pkg::NSR_DIV: begin
        if (div_done) begin
          // Half the distance between quotient and estimate, with its direction.
          if (div_q >= x_r) begin
            up_nxt  = 1'b1;
            mag_nxt = (div_q - x_r) >> 1;
          end else begin
            up_nxt  = 1'b0;
            mag_nxt = (x_r - div_q) >> 1;
          end
          state_nxt = nsr_pkg::NSR_UPD;
        end
      end
      nsr_pkg::NSR_UPD: begin
        x_nxt   = x_upd;
        cnt_nxt = cnt_inc;
        if ((mag_r <= RW'(tol_r)) || (cnt_inc == max_iter_r)) begin
          ov_nxt    = 1'b1;
          root_nxt  = x_upd;
          steps_nxt = cnt_inc;
          nerr_nxt  = 1'b0;
          state_nxt = nsr_pkg::NSR_IDLE;
        end else begin
          div_go      = 1'b1;
          div_divisor = x_upd;
          state_nxt   = nsr_pkg::NSR_DIV;
        end
      end
      default: state_nxt = nsr_pkg::NSR_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nsr_pkg::NSR_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    rad_r   <= rad_nxt;
    x_r     <= x_nxt;
    cnt_r   <= cnt_nxt;
    mag_r   <= mag_nxt;
    up_r    <= up_nxt;
    root_r  <= root_nxt;
    steps_r <= steps_nxt;
    nerr_r  <= nerr_nxt;
  end

  assign out_valid          = ov_r;
  assign out_root           = root_r;
  assign out_steps_taken    = steps_r;
  assign out_negative_error = nerr_r;

  // The estimate never reaches zero while an item iterates.
  a_x_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != nsr_pkg::NSR_IDLE) |-> (x_r != '0))
    else $error("estimate is zero during iteration");

  // A negative radicand reports a zero root and no steps.
  a_neg_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_negative_error) |-> (out_root == '0 && out_steps_taken == '0))
    else $error("negative item reported a root or steps");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == nsr_pkg::NSR_DIV))
    else $error("divider finished outside the divide state");

  // A result with steps always comes out of the update state.
  a_step_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_steps_taken != '0) |-> ($past(state_r) == nsr_pkg::NSR_UPD))
    else $error("result with steps not produced by an update");

endmodule
